// ===== hw/rtl/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared widths, constants and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

  localparam int unsigned SYM_W = 8;

  // rank returned when a forward symbol lies outside the alphabet
  localparam logic [SYM_W-1:0] RANK_NOT_FOUND = 8'hFF;

  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_INVERSE = 1'b1;

  typedef struct packed {
    logic             dir;    // mode of the item in flight
    logic [SYM_W-1:0] key;    // symbol searched in forward mode
    logic [SYM_W-1:0] pos;    // selected position (inverse lookup, then move)
    logic             shift;  // move the selected entry to the front
    logic             clear;  // return the list to identity order
  } cell_ctrl_t;

endpackage : mtf_pkg

`default_nettype wire

// ===== hw/rtl/mtf_in_if.sv =====
// ----------------------------------------------------------------------------
// mtf_in_if
// Input channel: one byte plus its end-of-block flag per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_block;

  modport source (output valid, output in_byte, output last_in_block, input ready);
  modport sink   (input valid, input in_byte, input last_in_block, output ready);
endinterface : mtf_in_if

`default_nettype wire

// ===== hw/rtl/mtf_out_if.sv =====
// ----------------------------------------------------------------------------
// mtf_out_if
// Output channel: one result byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface : mtf_out_if

`default_nettype wire

// ===== hw/rtl/mtf_cell.sv =====
// ----------------------------------------------------------------------------
// mtf_cell
// One list entry: matches against the lookup and, when the selected entry moves
// to the front, takes its left neighbour's symbol if it lies at or before the selected position.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_cell #(
  parameter int unsigned J = 0
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mtf_pkg::cell_ctrl_t     ctrl_i,
  input  wire logic [mtf_pkg::SYM_W-1:0] left_i,
  output logic      [mtf_pkg::SYM_W-1:0] sym_o,
  output logic                         hit_o,
  output logic      [mtf_pkg::SYM_W-1:0] tap_o
);
  import mtf_pkg::*;

  localparam logic [SYM_W-1:0] MY_POS = SYM_W'(J);

  logic [SYM_W-1:0] sym_q, sym_d;

  always_comb begin
    if (ctrl_i.dir == DIR_INVERSE) begin
      hit_o = (ctrl_i.pos == MY_POS);
      tap_o = hit_o ? sym_q : '0;
    end else begin
      hit_o = (sym_q == ctrl_i.key);
      tap_o = hit_o ? MY_POS : '0;
    end
  end

  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.clear) begin
      sym_d = MY_POS;
    end else if (ctrl_i.shift && (MY_POS <= ctrl_i.pos)) begin
      sym_d = left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= MY_POS;
    end else begin
      sym_q <= sym_d;
    end
  end

  assign sym_o = sym_q;

endmodule : mtf_cell

`default_nettype wire

// ===== hw/rtl/move_to_front_transform.sv =====
// ----------------------------------------------------------------------------
// move_to_front_transform
// Byte-wise move-to-front coder and decoder over a row of list cells.
// ----------------------------------------------------------------------------
//  channel     dir  handshake     word
//  in_i        in   valid/ready   in_byte[7:0], last_in_block
//  out_o       out  valid/ready   out_byte[7:0]
//  direction   in   we/wdata      0 forward, 1 inverse
//
//  an item passes capture, lookup across all cells and a shift of the cells up
//  to the selected position; a new word is taken once the shift ends.
//  lookup waits in place while a previous result has not been taken.
//  reset puts the list in identity order and direction to forward.
// ----------------------------------------------------------------------------
`default_nettype none

module move_to_front_transform #(
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic direction_we_i,
  input  wire logic direction_wdata_i,
  mtf_in_if.sink    in_i,
  mtf_out_if.source out_o
);
  import mtf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;

  localparam logic [SYM_W:0]   ALPHA_EXT = (SYM_W+1)'(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0] LAST_POS  = SYM_W'(ALPHABET_SIZE - 1);

  logic [1:0]       state_q, state_d;
  logic             direction_q;
  logic             dir_q;
  logic             last_q;
  logic [SYM_W-1:0] key_q;
  logic [SYM_W-1:0] pos_q, pos_d;
  logic [SYM_W-1:0] front_q, front_d;
  logic             found_q, found_d;
  logic             out_valid_q;
  logic [SYM_W-1:0] out_byte_q;

  logic             in_fire;
  logic             look_done;
  logic [SYM_W-1:0] sat_pos;
  cell_ctrl_t       ctrl;

  logic [SYM_W-1:0] chain [ALPHABET_SIZE+1];
  logic [ALPHABET_SIZE-1:0] hits;
  logic [SYM_W-1:0] taps [ALPHABET_SIZE];
  logic [SYM_W-1:0] tap_or;
  logic             any_hit;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign look_done  = (state_q == ST_LOOK) && (!out_valid_q || out_o.ready);

  assign sat_pos = ({1'b0, in_i.in_byte} >= ALPHA_EXT) ? LAST_POS : in_i.in_byte;

  always_comb begin
    ctrl.dir   = dir_q;
    ctrl.key   = key_q;
    ctrl.pos   = pos_q;
    ctrl.shift = (state_q == ST_MOVE) && found_q;
    ctrl.clear = (state_q == ST_MOVE) && last_q;
  end

  // the moving symbol enters the front of the row
  assign chain[0] = front_q;

  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
    mtf_cell #(.J(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (chain[g]),
      .sym_o  (chain[g+1]),
      .hit_o  (hits[g]),
      .tap_o  (taps[g])
    );
  end

  // at most one cell hits, so an or over the taps encodes it
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      tap_or = tap_or | taps[i];
    end
  end
  assign any_hit = |hits;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    front_d = front_q;
    found_d = found_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pos_d   = sat_pos;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (look_done) begin
          if (dir_q == DIR_INVERSE) begin
            front_d = tap_or;
            found_d = 1'b1;
          end else begin
            pos_d   = tap_or;
            front_d = key_q;
            found_d = any_hit;
          end
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      direction_q <= DIR_FORWARD;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (direction_we_i) begin
        direction_q <= direction_wdata_i;
      end
      if (in_fire) begin
        last_q <= in_i.last_in_block;
      end
      if (look_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    front_q <= front_d;
    if (in_fire) begin
      key_q <= in_i.in_byte;
      dir_q <= direction_q;
    end
    if (look_done) begin
      if ((dir_q == DIR_FORWARD) && !any_hit) begin
        out_byte_q <= RANK_NOT_FOUND;
      end else begin
        out_byte_q <= tap_or;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

endmodule : move_to_front_transform

`default_nettype wire
